### design/catan_pkg.sv
// ============================================================================
// catan_pkg
// Shared types, constants and the angle table for the CORDIC arctangent.
// ============================================================================
package catan_pkg;

    localparam int ITERATIONS = 12;
    localparam int DATA_W     = 32;
    localparam int ANGLE_W    = 12;
    localparam int SHIFT_W    = $clog2(ITERATIONS + 1);

    typedef logic [DATA_W-1:0]  data_t;
    typedef logic [ANGLE_W-1:0] angle_t;
    typedef logic [SHIFT_W-1:0] shift_t;

    // Starting x: 1.0 in Q12.
    localparam data_t START_X = data_t'(4096);

    // Vector state carried from one rotation step to the next.
    typedef struct packed {
        data_t  x;
        data_t  y;
        angle_t z;
    } vec_t;

    // Elementary rotation angles, 4096 units per turn.
    function automatic angle_t atan_entry(input int unsigned idx);
        angle_t val;
        case (idx)
            0:       val = angle_t'(511);
            1:       val = angle_t'(302);
            2:       val = angle_t'(159);
            3:       val = angle_t'(81);
            4:       val = angle_t'(41);
            5:       val = angle_t'(20);
            6:       val = angle_t'(10);
            7:       val = angle_t'(5);
            8:       val = angle_t'(3);
            9:       val = angle_t'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

### design/catan_step.sv
// ============================================================================
// catan_step
// One vectoring rotation: shift, add or subtract, and angle accumulate.
// ============================================================================
module catan_step
    import catan_pkg::*;
(
    input  vec_t   cur,
    input  shift_t shift,
    input  angle_t rot,
    output vec_t   nxt
);

    logic signed [DATA_W-1:0] x_s;
    logic signed [DATA_W-1:0] y_s;
    data_t                    dx;
    data_t                    dy;

    always_comb
    begin
        x_s = cur.x;
        y_s = cur.y;
        dx  = data_t'(x_s >>> shift);
        dy  = data_t'(y_s >>> shift);
        // Rotate toward the x axis: the sign of y picks the direction.
        if (cur.y[DATA_W-1])
        begin
            nxt.x = cur.x - dy;
            nxt.y = cur.y + dx;
            nxt.z = cur.z - rot;
        end
        else
        begin
            nxt.x = cur.x + dy;
            nxt.y = cur.y - dx;
            nxt.z = cur.z + rot;
        end
    end

endmodule

### design/cordic_arctangent.sv
// ============================================================================
// cordic_arctangent
// Pipelined vectoring CORDIC that turns a Q12 ratio into its arctangent.
// ============================================================================
// Pipeline: an accepted word moves through one stage per rotation step and
// shows on angle_valid from the last stage, where it waits to be taken.
// Throughput: one word per cycle; each stage holds under backpressure, so
// only the stages behind a stalled stage wait while bubbles still fill.
// Reset: rst_n clears every stage's valid bit at once; data registers are
// not reset.
// ============================================================================
module cordic_arctangent
    import catan_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       ratio_valid,
    output logic                       ratio_ready,
    input  logic signed [DATA_W-1:0]   ratio,
    output logic                       angle_valid,
    input  logic                       angle_ready,
    output logic signed [ANGLE_W-1:0]  angle
);

    // Each stage i holds the vector after rotation step i. The last stage
    // doubles as the output register, so a waiting result never blocks the
    // earlier stages from taking new words while they have room.
    vec_t vec_reg   [ITERATIONS];
    vec_t vec_next  [ITERATIONS];
    vec_t stage_in  [ITERATIONS];
    logic valid_reg [ITERATIONS];
    logic up_valid  [ITERATIONS];

    // Stage i may load when it is empty or its content moves on this edge.
    logic [ITERATIONS:0] advance;

    assign advance[ITERATIONS] = angle_ready;

    genvar i;
    generate
        for (i = 0; i < ITERATIONS; i++)
        begin : g_stage
            if (i == 0)
            begin : g_first
                // The ratio enters as y over an x of 1.0 with no angle yet.
                assign stage_in[i] = '{x: START_X, y: data_t'(ratio), z: '0};
                assign up_valid[i] = ratio_valid;
            end
            else
            begin : g_rest
                assign stage_in[i] = vec_reg[i-1];
                assign up_valid[i] = valid_reg[i-1];
            end

            assign advance[i] = !valid_reg[i] || advance[i+1];

            catan_step u_step (
                .cur   (stage_in[i]),
                .shift (shift_t'(i)),
                .rot   (atan_entry(i)),
                .nxt   (vec_next[i])
            );

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i] <= 1'b0;
                end
                else if (advance[i])
                begin
                    valid_reg[i] <= up_valid[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance[i] && up_valid[i])
                begin
                    vec_reg[i] <= vec_next[i];
                end
            end
        end
    endgenerate

    assign ratio_ready = advance[0];
    assign angle_valid = valid_reg[ITERATIONS-1];
    assign angle       = $signed(vec_reg[ITERATIONS-1].z);

endmodule

### design/catan_check.sv
// ============================================================================
// catan_check
// Port-level checks on the CORDIC arctangent, bound to the top level.
// ============================================================================
module catan_check
    import catan_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       ratio_valid,
    input logic                       ratio_ready,
    input logic                       angle_valid,
    input logic                       angle_ready,
    input logic signed [ANGLE_W-1:0]  angle
);

    // Count of consecutive edges with the output side ready, saturating.
    logic [SHIFT_W-1:0] ready_run_reg;
    logic [SHIFT_W-1:0] ready_run_next;

    always_comb
    begin
        if (!angle_ready)
        begin
            ready_run_next = '0;
        end
        else if (ready_run_reg == shift_t'(ITERATIONS))
        begin
            ready_run_next = ready_run_reg;
        end
        else
        begin
            ready_run_next = ready_run_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_run_reg <= '0;
        end
        else
        begin
            ready_run_reg <= ready_run_next;
        end
    end

    // A ready output side lets the whole pipeline flow.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        angle_ready |-> ratio_ready)
        else $error("input not ready while output side is ready");

    // The angle is a sum of table entries and stays in range.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid |-> (angle >= -1133) && (angle <= 1133))
        else $error("angle out of range");

    // With no backpressure a word comes out after the full pipeline depth.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(ratio_valid && ratio_ready && rst_n, ITERATIONS)
            && (ready_run_reg >= shift_t'(ITERATIONS - 1)))
        |-> angle_valid)
        else $error("result missing after pipeline latency");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (angle_valid && !angle_ready) |=> (angle_valid && $stable(angle)))
        else $error("stalled result changed");

endmodule

bind cordic_arctangent catan_check u_catan_check (.*);
